@@ rtl/core/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Transport stream packetizer package
// Shared sizes, the table entry layout, the sequencer states and the helper
// functions for header assembly and tail stuffing.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int PID_ENTRIES       = 16;
  localparam int IDX_W             = (PID_ENTRIES > 1) ? $clog2(PID_ENTRIES) : 1;
  localparam int PID_W             = 13;
  localparam int CC_W              = 4;
  localparam int WORD_W            = 32;
  localparam int VB_W              = 3;
  localparam int WORDS_PER_PAYLOAD = 46;
  localparam int POS_W             = 6;

  localparam logic [7:0]        SYNC_BYTE     = 8'h47;
  localparam logic [1:0]        ADAPT_PAYLOAD = 2'b01;
  localparam logic [WORD_W-1:0] STUFF_WORD    = 32'hFFFF_FFFF;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [CC_W-1:0]  cc;
  } pid_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_HDR_RD,
    ST_HDR,
    ST_DATA,
    ST_STUFF
  } tsp_state_t;

  // Bytes past the valid count of a closing word are replaced by 0xFF.
  function automatic logic [WORD_W-1:0] tail_fill(input logic [WORD_W-1:0] word,
                                                  input logic [VB_W-1:0]   vb);
    logic [WORD_W-1:0] res;
    case (vb)
      3'd0:    res = STUFF_WORD;
      3'd1:    res = {word[31:24], 24'hFF_FFFF};
      3'd2:    res = {word[31:16], 16'hFFFF};
      3'd3:    res = {word[31:8], 8'hFF};
      default: res = word;
    endcase
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] make_header(input logic             pusi,
                                                    input logic [PID_W-1:0] pid,
                                                    input logic [CC_W-1:0]  cc);
    return {SYNC_BYTE, 1'b0, pusi, 1'b0, pid, 2'b00, ADAPT_PAYLOAD, cc};
  endfunction

endpackage

@@ rtl/core/tsp_if.sv @@
// ----------------------------------------------------------------------------
// Transport stream packetizer channels
// Valid/ready channels for incoming section words and outgoing packet words.
// ----------------------------------------------------------------------------
interface tsp_in_if import tsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PID_W-1:0]  pid;
  logic [WORD_W-1:0] data_word;
  logic [VB_W-1:0]   valid_bytes;
  logic              section_end;

  modport source (output valid, pid, data_word, valid_bytes, section_end,
                  input ready);
  modport sink (input valid, pid, data_word, valid_bytes, section_end,
                output ready);
endinterface

interface tsp_out_if import tsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] ts_word;
  logic              packet_start;
  logic              packet_end;
  logic              table_full;
  logic              last_of_run;

  modport source (output valid, ts_word, packet_start, packet_end, table_full,
                  last_of_run, input ready);
  modport sink (input valid, ts_word, packet_start, packet_end, table_full,
                last_of_run, output ready);
endinterface

@@ rtl/core/ts_section_packetizer.sv @@
// ----------------------------------------------------------------------------
// Section to transport stream packetizer
// Cuts sections of 32-bit words into 47-word (188-byte) transport packets.
// ----------------------------------------------------------------------------
// Usage: section words enter on in_ch, one transfer per word, the last word
// flagged by section_end. Packet words leave on out_ch: a header word opens
// each packet, then 46 payload words; the last packet of a section is padded
// with 0xFF words. last_of_run marks the final output word of each input word.
// Sequence: in_ch is ready only while the sequencer is idle. An ordinary
// payload word is transferred in, then transferred out. A word that opens a
// packet also passes a table read and the header before its payload word.
// The first word of a section also runs the PID search over the table, one
// entry at a time (a read state, then a compare state) through one comparator
// and the table read port; a hit ends it early. Stuffing sends padding words.
// Reset: all table entries invalid, no section open. There is no clearing
// pass. A stall on out_ch simply holds the current word and the sequencer.
// ----------------------------------------------------------------------------
module ts_section_packetizer import tsp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  tsp_in_if.sink     in_ch,
  tsp_out_if.source  out_ch
);

  localparam idx_t                 LAST_IDX = idx_t'(PID_ENTRIES - 1);
  localparam logic [POS_W-1:0]     LAST_POS = POS_W'(WORDS_PER_PAYLOAD - 1);

  tsp_state_t state_r, state_nxt;

  logic [WORD_W-1:0]      word_r, word_nxt;
  logic                   last_r, last_nxt;
  logic [PID_W-1:0]       pid_r, pid_nxt;
  idx_t                   entry_r, entry_nxt;
  idx_t                   idx_r, idx_nxt;
  idx_t                   free_r, free_nxt;
  logic                   have_free_r, have_free_nxt;
  logic                   no_entry_r, no_entry_nxt;
  logic [CC_W-1:0]        spare_r, spare_nxt;
  logic                   first_r, first_nxt;
  logic                   inside_r, inside_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [PID_ENTRIES-1:0] valid_r, valid_nxt;

  pid_entry_t table_mem [PID_ENTRIES];
  pid_entry_t rd_data_r;
  idx_t       rd_addr;
  logic       wr_en;
  idx_t       wr_addr;
  pid_entry_t wr_data;

  logic       in_xfer, out_xfer;
  logic       pkt_end;
  logic       hit, free_here;
  logic [CC_W-1:0] hdr_cc;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_ch.valid && out_ch.ready;
  assign pkt_end   = (pos_r == LAST_POS);
  assign hit       = valid_r[idx_r] && (rd_data_r.pid == pid_r);
  assign free_here = !valid_r[idx_r] && !have_free_r;
  assign hdr_cc    = no_entry_r ? spare_r : rd_data_r.cc;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!inside_r) begin
            state_nxt = ST_SEARCH;
          end else if (pos_r == '0) begin
            state_nxt = ST_HDR_RD;
          end else begin
            state_nxt = ST_DATA;
          end
        end
      end
      ST_SEARCH: state_nxt = ST_CMP;
      ST_CMP: begin
        if (hit || (idx_r == LAST_IDX)) begin
          state_nxt = ST_HDR_RD;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_HDR_RD: state_nxt = ST_HDR;
      ST_HDR: begin
        if (out_xfer) begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (out_xfer) begin
          state_nxt = (last_r && !pkt_end) ? ST_STUFF : ST_IDLE;
        end
      end
      ST_STUFF: begin
        if (out_xfer && pkt_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake, output payload and table read address.
  always_comb begin
    in_ch.ready         = 1'b0;
    out_ch.valid        = 1'b0;
    out_ch.ts_word      = word_r;
    out_ch.packet_start = 1'b0;
    out_ch.packet_end   = 1'b0;
    out_ch.table_full   = no_entry_r;
    out_ch.last_of_run  = 1'b0;
    rd_addr             = idx_r;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SEARCH, ST_CMP: rd_addr = idx_r;
      ST_HDR_RD: rd_addr = entry_r;
      ST_HDR: begin
        rd_addr             = entry_r;
        out_ch.valid        = 1'b1;
        out_ch.ts_word      = make_header(first_r, pid_r, hdr_cc);
        out_ch.packet_start = 1'b1;
      end
      ST_DATA: begin
        out_ch.valid       = 1'b1;
        out_ch.packet_end  = pkt_end;
        out_ch.last_of_run = !last_r || pkt_end;
      end
      ST_STUFF: begin
        out_ch.valid       = 1'b1;
        out_ch.ts_word     = STUFF_WORD;
        out_ch.packet_end  = pkt_end;
        out_ch.last_of_run = pkt_end;
      end
      default: ;
    endcase
  end

  // Datapath and table updates.
  always_comb begin
    word_nxt      = word_r;
    last_nxt      = last_r;
    pid_nxt       = pid_r;
    entry_nxt     = entry_r;
    idx_nxt       = idx_r;
    free_nxt      = free_r;
    have_free_nxt = have_free_r;
    no_entry_nxt  = no_entry_r;
    spare_nxt     = spare_r;
    first_nxt     = first_r;
    inside_nxt    = inside_r;
    pos_nxt       = pos_r;
    valid_nxt     = valid_r;
    wr_en         = 1'b0;
    wr_addr       = entry_r;
    wr_data       = '{pid: pid_r, cc: rd_data_r.cc + 1'b1};

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          word_nxt = in_ch.section_end ? tail_fill(in_ch.data_word, in_ch.valid_bytes)
                                       : in_ch.data_word;
          last_nxt = in_ch.section_end;
          if (!inside_r) begin
            pid_nxt       = in_ch.pid;
            idx_nxt       = '0;
            have_free_nxt = 1'b0;
            no_entry_nxt  = 1'b0;
            spare_nxt     = '0;
            first_nxt     = 1'b1;
            inside_nxt    = 1'b1;
            pos_nxt       = '0;
          end
        end
      end
      ST_CMP: begin
        if (hit) begin
          entry_nxt = idx_r;
        end else begin
          if (free_here) begin
            free_nxt      = idx_r;
            have_free_nxt = 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            // End of the scan: claim the first free entry, if there was one.
            if (have_free_r || free_here) begin
              entry_nxt = have_free_r ? free_r : idx_r;
              wr_en     = 1'b1;
              wr_addr   = have_free_r ? free_r : idx_r;
              wr_data   = '{pid: pid_r, cc: '0};
              valid_nxt[have_free_r ? free_r : idx_r] = 1'b1;
            end else begin
              no_entry_nxt = 1'b1;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_HDR: begin
        if (out_xfer) begin
          first_nxt = 1'b0;
          if (no_entry_r) begin
            spare_nxt = spare_r + 1'b1;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      ST_DATA, ST_STUFF: begin
        if (out_xfer) begin
          pos_nxt = pkt_end ? '0 : pos_r + 1'b1;
          if (last_r && pkt_end) begin
            inside_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inside_r    <= 1'b0;
      pos_r       <= '0;
      valid_r     <= '0;
      entry_r     <= '0;
      pid_r       <= '0;
      no_entry_r  <= 1'b0;
      spare_r     <= '0;
      first_r     <= 1'b0;
      have_free_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      inside_r    <= inside_nxt;
      pos_r       <= pos_nxt;
      valid_r     <= valid_nxt;
      entry_r     <= entry_nxt;
      pid_r       <= pid_nxt;
      no_entry_r  <= no_entry_nxt;
      spare_r     <= spare_nxt;
      first_r     <= first_nxt;
      have_free_r <= have_free_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    last_r <= last_nxt;
    free_r <= free_nxt;
  end

  // The block never holds an input word and an output word at once.
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while a packet word is pending");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("payload position beyond packet size");

  a_hdr_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HDR && out_xfer) |=> (state_r == ST_DATA && pos_r == $past(pos_r)))
    else $error("header transfer not followed by its payload word");

  // Running without a table entry is only possible when every entry is taken.
  a_full_table: assert property (@(posedge clk) disable iff (!rst_n)
    (no_entry_r && inside_r) |-> (&valid_r))
    else $error("no table entry although a free one exists");

  a_stuff_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STUFF && out_xfer && pkt_end) |=> (state_r == ST_IDLE && !inside_r))
    else $error("section not closed after the last stuffing word");

endmodule

@@ tb/tb_ts_section_packetizer.sv @@
// ----------------------------------------------------------------------------
// Testbench for the section to transport stream packetizer
// Sends sections of 32-bit words with random content and lengths, predicts
// every packet word (header, payload, 0xFF stuffing, PID table and counters)
// and checks each output transfer against the oldest predicted word. The
// sender idles in random bursts and the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module tb_ts_section_packetizer;
  import tsp_pkg::*;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [WORD_W-1:0] data;
    logic [VB_W-1:0]   nbytes;
    logic              last;
  } sec_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              hdr;
    logic              pkt_end;
    logic              full;
    logic              run_last;
  } ts_word_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_RARE_STALL, RX_PERIODIC} rx_pattern_t;

  // Predicts packet words for each section word and checks what comes out.
  class packetizer_sb;
    logic             slot_used [PID_ENTRIES];
    logic [PID_W-1:0] slot_pid  [PID_ENTRIES];
    logic [CC_W-1:0]  slot_cc   [PID_ENTRIES];
    int               pos;
    bit               in_section;
    int               cur_slot;
    logic [PID_W-1:0] cur_pid;
    bit               no_slot;
    logic [CC_W-1:0]  spare_cc;
    ts_word_t         packet_words[$];
    int               errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_pid[i]  = '0;
        slot_cc[i]   = '0;
      end
      pos        = 0;
      in_section = 0;
      cur_slot   = 0;
      cur_pid    = '0;
      no_slot    = 0;
      spare_cc   = '0;
      errors     = 0;
    endfunction

    function int pending();
      return packet_words.size();
    endfunction

    // Finds the PID in the table or claims the lowest free entry.
    function void open_section(logic [PID_W-1:0] pid);
      int  free_slot;
      bit  have_free;
      free_slot = 0;
      have_free = 0;
      cur_pid   = pid;
      no_slot   = 0;
      spare_cc  = '0;
      for (int i = 0; i < PID_ENTRIES; i++) begin
        if (slot_used[i] && slot_pid[i] == pid) begin
          cur_slot = i;
          return;
        end
        if (!slot_used[i] && !have_free) begin
          have_free = 1;
          free_slot = i;
        end
      end
      if (have_free) begin
        cur_slot            = free_slot;
        slot_used[free_slot] = 1'b1;
        slot_pid[free_slot]  = pid;
        slot_cc[free_slot]   = '0;
      end else begin
        no_slot = 1;
      end
    endfunction

    function logic [CC_W-1:0] next_cc();
      logic [CC_W-1:0] cc;
      if (no_slot) begin
        cc       = spare_cc;
        spare_cc = cc + 1'b1;
      end else begin
        cc                = slot_cc[cur_slot];
        slot_cc[cur_slot] = cc + 1'b1;
      end
      return cc;
    endfunction

    function void push_word(logic [WORD_W-1:0] word, logic hdr, logic pkt_end);
      ts_word_t w;
      w.word     = word;
      w.hdr      = hdr;
      w.pkt_end  = pkt_end;
      w.full     = no_slot;
      w.run_last = 1'b0;
      packet_words = {packet_words, w};
    endfunction

    function void note_word(sec_word_t w);
      logic [WORD_W-1:0] payload;
      logic              first;
      int                nb;
      first = 1'b0;
      if (!in_section) begin
        open_section(w.pid);
        in_section = 1;
        pos        = 0;
        first      = 1'b1;
      end
      if (pos == 0)
        push_word({SYNC_BYTE, 1'b0, first, 1'b0, cur_pid, 2'b00, ADAPT_PAYLOAD, next_cc()},
                  1'b1, 1'b0);
      payload = w.data;
      if (w.last) begin
        nb = (w.nbytes > 4) ? 4 : int'(w.nbytes);
        // Bytes past the valid count turn into 0xFF; a full word keeps all.
        payload = payload | (STUFF_WORD >> (nb * 8));
      end
      pos++;
      push_word(payload, 1'b0, pos == WORDS_PER_PAYLOAD);
      if (pos == WORDS_PER_PAYLOAD) pos = 0;
      if (w.last) begin
        while (pos != 0) begin
          pos++;
          push_word(STUFF_WORD, 1'b0, pos == WORDS_PER_PAYLOAD);
          if (pos == WORDS_PER_PAYLOAD) pos = 0;
        end
        in_section = 0;
      end
      packet_words[packet_words.size() - 1].run_last = 1'b1;
    endfunction

    function void check_word(ts_word_t got);
      ts_word_t want;
      if (packet_words.size() == 0) begin
        $error("unexpected output transfer, ts_word %h", got.word);
        errors++;
        return;
      end
      want = packet_words[0];
      packet_words.delete(0);
      if (got.word !== want.word) begin
        $error("ts_word: expected %h, got %h", want.word, got.word);
        errors++;
      end
      if (got.hdr !== want.hdr) begin
        $error("packet_start: expected %b, got %b", want.hdr, got.hdr);
        errors++;
      end
      if (got.pkt_end !== want.pkt_end) begin
        $error("packet_end: expected %b, got %b", want.pkt_end, got.pkt_end);
        errors++;
      end
      if (got.full !== want.full) begin
        $error("table_full: expected %b, got %b", want.full, got.full);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("last_of_run: expected %b, got %b", want.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tsp_in_if  in_ch();
  tsp_out_if out_ch();

  ts_section_packetizer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  packetizer_sb sb = new();

  int          words_sent = 0;
  int          burst_left = 0;
  bit          hold_req   = 0;
  int          hold_left  = 0;
  rx_pattern_t rx_pattern = RX_OPEN;
  int          rx_left    = 0;
  int          rx_phase   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: a changing stall pattern, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        rx_left    = $urandom_range(20, 200);
      end
      rx_left--;
      rx_phase++;
      case (rx_pattern)
        RX_OPEN:       out_ch.ready <= 1'b1;
        RX_COIN:       out_ch.ready <= 1'($urandom_range(0, 1));
        RX_RARE_STALL: out_ch.ready <= ($urandom_range(0, 7) != 0);
        default:       out_ch.ready <= ((rx_phase % 5) >= 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word({out_ch.ts_word, out_ch.packet_start, out_ch.packet_end,
                     out_ch.table_full, out_ch.last_of_run});
  end

  task automatic send_word(input sec_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.pid         <= w.pid;
    in_ch.data_word   <= w.data;
    in_ch.valid_bytes <= w.nbytes;
    in_ch.section_end <= w.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  // The PID only matters on the first word; later words carry noise there.
  task automatic send_section(input logic [PID_W-1:0] pid, input int nwords,
                              input logic [VB_W-1:0] last_nb);
    sec_word_t w;
    int        pick;
    for (int i = 0; i < nwords; i++) begin
      pick     = $urandom_range(0, 9);
      w.pid    = (i == 0) ? pid : PID_W'($urandom);
      w.data   = (pick == 0) ? '0 : (pick == 1) ? STUFF_WORD : $urandom;
      w.last   = (i == nwords - 1);
      w.nbytes = w.last ? last_nb :
                 (($urandom_range(0, 4) == 0) ? VB_W'($urandom_range(0, 7)) : 3'd4);
      send_word(w);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [PID_W-1:0] pid_pool [24];
    logic [VB_W-1:0]  last_nb;
    logic [PID_W-1:0] pid;
    int               nwords;
    int               sel;
    int               sections;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.pid         <= '0;
    in_ch.data_word   <= '0;
    in_ch.valid_bytes <= '0;
    in_ch.section_end <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, short and oversized byte counts,
    // ignored fields on non-final words, PID hits and a full table.
    send_word('{pid: 13'd0,    data: 32'h0000_0000, nbytes: 3'd4, last: 1'b1});
    send_word('{pid: 13'h1FFF, data: 32'hFFFF_FFFF, nbytes: 3'd2, last: 1'b0});
    send_word('{pid: 13'd0,    data: 32'h1234_5678, nbytes: 3'd1, last: 1'b1});
    send_word('{pid: 13'd0,    data: 32'hA5A5_5A5A, nbytes: 3'd0, last: 1'b1});
    send_word('{pid: 13'h1FFF, data: 32'hDEAD_BEEF, nbytes: 3'd3, last: 1'b1});
    send_word('{pid: 13'h0AAA, data: 32'h0F0F_F0F0, nbytes: 3'd7, last: 1'b1});
    send_word('{pid: 13'h1555, data: 32'h8000_0001, nbytes: 3'd5, last: 1'b1});
    send_word('{pid: 13'h0AAA, data: 32'h7FFF_FFFE, nbytes: 3'd6, last: 1'b1});
    pid_pool[0] = 13'd0;
    pid_pool[1] = 13'h1FFF;
    pid_pool[2] = 13'h0AAA;
    pid_pool[3] = 13'h1555;
    // Twelve more PIDs fill the table; the next two find no free entry.
    for (int i = 1; i <= 14; i++) begin
      pid_pool[3 + i] = PID_W'(i);
      send_section(PID_W'(i), (i == 14) ? 2 : 1, 3'd4);
    end
    for (int i = 18; i < 24; i++) pid_pool[i] = PID_W'($urandom);
    wait_drained();

    sections = 0;
    while (words_sent < 500) begin
      if (sections == 4) hold_req = 1;
      if (sections == 15) wait_drained();
      sel = $urandom_range(0, 99);
      if (sel < 80)      nwords = $urandom_range(1, 8);
      else if (sel < 88) nwords = $urandom_range(40, 50);
      else if (sel < 95) nwords = $urandom_range(0, 1) ? 46 : 92;
      else               nwords = $urandom_range(85, 100);
      if (nwords % WORDS_PER_PAYLOAD == 0)
        last_nb = VB_W'($urandom_range(4, 7));
      else if ($urandom_range(0, 9) < 5)
        last_nb = 3'd4;
      else
        last_nb = VB_W'($urandom_range(0, 7));
      pid = ($urandom_range(0, 9) == 0) ? PID_W'($urandom) : pid_pool[$urandom_range(0, 23)];
      send_section(pid, nwords, last_nb);
      sections++;
    end
    wait_drained();
    repeat (60) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tsp_pkg.sv
rtl/core/tsp_if.sv
rtl/core/ts_section_packetizer.sv
tb/tb_ts_section_packetizer.sv
